>>> rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
// Used by i2cm_front, i2cm_back and the top level i2c_master_byte_engine.
`timescale 1ns / 1ps

package i2cm_pkg;

   // Command codes as they arrive on the request channel
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // Reset value of the timing register
   localparam logic [15:0] TICKS_PER_UNIT_RESET = 16'd100;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Classified operation carried through the queue
   typedef enum logic [2:0] {
      OP_NONE,
      OP_TICK,
      OP_START,
      OP_STOP,
      OP_WRITE,
      OP_READ
   } op_type;

   // One queued word
   typedef struct packed {
      op_type     op;
      logic [7:0] tx_byte;
      logic       ack_mode;
      logic       sda_sample;
   } item_type;

endpackage

>>> rtl/i2cm_front.sv
// Front end of the I2C master byte engine: classifies request words and
// queues them for the sequencer. Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_front #(
   parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic [7:0]         req_tx_byte,
   input  logic               req_ack_mode,
   input  logic               req_sda_in,
   output logic               q_valid,
   output i2cm_pkg::item_type q_item,
   input  logic               q_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   i2cm_pkg::item_type q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   i2cm_pkg::item_type item_new;
   logic               push;

   // Classify the incoming command
   always_comb begin
      item_new.tx_byte    = req_tx_byte;
      item_new.ack_mode   = req_ack_mode;
      item_new.sda_sample = req_sda_in;
      unique case (req_cmd)
         i2cm_pkg::CMD_TICK:  item_new.op = i2cm_pkg::OP_TICK;
         i2cm_pkg::CMD_START: item_new.op = i2cm_pkg::OP_START;
         i2cm_pkg::CMD_STOP:  item_new.op = i2cm_pkg::OP_STOP;
         i2cm_pkg::CMD_WRITE: item_new.op = i2cm_pkg::OP_WRITE;
         i2cm_pkg::CMD_READ:  item_new.op = i2cm_pkg::OP_READ;
         default:             item_new.op = i2cm_pkg::OP_NONE;
      endcase
   end

   // Queue handshake
   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

>>> rtl/i2cm_back.sv
// Back end of the I2C master byte engine: bus sequencer with pin state and
// a registered response stage. Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        ticks_per_unit,
   input  logic               q_valid,
   input  i2cm_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_scl_level,
   output logic               rsp_sda_level,
   output logic               rsp_sda_drive,
   output logic               rsp_busy_res,
   output logic               rsp_done_res,
   output logic [7:0]         rsp_rx_byte,
   output logic               rsp_ack_level,
   output logic               rsp_rejected
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_P1, ST_P2,
      ST_W1, ST_W2, ST_W3, ST_WA1, ST_WA2, ST_WEND,
      ST_R0, ST_R1, ST_R2, ST_RA1, ST_RA2, ST_REND
   } step_type;

   step_type    step_ff, step_in;
   logic [15:0] pre_ff, pre_in;
   logic [5:0]  units_ff, units_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic        lam_ff, lam_in;
   logic        ack_ff, ack_in;
   logic        scl_out_ff, scl_out_in;
   logic        sda_out_ff, sda_out_in;
   logic        sda_oe_ff, sda_oe_in;
   logic [7:0]  rx_ff, rx_in;

   logic        rsp_valid_ff;
   logic        rsp_scl_ff, rsp_sda_ff, rsp_oe_ff, rsp_busy_ff, rsp_done_ff;
   logic [7:0]  rsp_rx_ff;
   logic        rsp_ack_ff, rsp_rej_ff;

   logic        busy;
   logic        done;
   logic        rej;
   logic [15:0] tpu_eff;
   logic [16:0] pre_sum;
   logic [5:0]  units_dec;
   logic [7:0]  shift_up;
   logic [3:0]  bit_up;

   assign busy     = (step_ff != ST_IDLE);
   assign tpu_eff  = (ticks_per_unit == 16'd0) ? 16'd1 : ticks_per_unit;
   assign pre_sum  = {1'b0, pre_ff} + 17'd1;
   assign units_dec = (units_ff != 6'd0) ? units_ff - 6'd1 : 6'd0;
   assign shift_up = {shift_ff[6:0], 1'b0};
   assign bit_up   = bit_ff + 4'd1;

   // Take a word when the response stage is free or being drained
   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   // Sequencer next state
   always_comb begin
      step_in    = step_ff;
      pre_in     = pre_ff;
      units_in   = units_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      lam_in     = lam_ff;
      ack_in     = ack_ff;
      scl_out_in = scl_out_ff;
      sda_out_in = sda_out_ff;
      sda_oe_in  = sda_oe_ff;
      rx_in      = rx_ff;
      done       = 1'b0;
      rej        = 1'b0;
      case (q_item.op)
         i2cm_pkg::OP_TICK: begin
            if (busy) begin
               if (pre_sum >= {1'b0, tpu_eff}) begin
                  pre_in   = 16'd0;
                  units_in = units_dec;
                  if (units_dec == 6'd0) begin
                     // End of a wait: perform the next pin action
                     unique case (step_ff)
                        ST_S1: begin
                           sda_out_in = 1'b1; units_in = 6'd1; step_in = ST_S2;
                        end
                        ST_S2: begin
                           scl_out_in = 1'b1; units_in = 6'd10; step_in = ST_S3;
                        end
                        ST_S3: begin
                           sda_out_in = 1'b0; units_in = 6'd1; step_in = ST_S4;
                        end
                        ST_S4: begin
                           scl_out_in = 1'b0; units_in = 6'd2; step_in = ST_S5;
                        end
                        ST_P1: begin
                           scl_out_in = 1'b1; units_in = 6'd2; step_in = ST_P2;
                        end
                        ST_P2: begin
                           sda_out_in = 1'b1; step_in = ST_IDLE; done = 1'b1;
                        end
                        ST_W1: begin
                           scl_out_in = 1'b1; units_in = 6'd2; step_in = ST_W2;
                        end
                        ST_W2: begin
                           scl_out_in = 1'b0; units_in = 6'd1; step_in = ST_W3;
                        end
                        ST_W3: begin
                           shift_in = shift_up;
                           bit_in   = bit_up;
                           if (bit_up < 4'd8) begin
                              sda_out_in = shift_up[7];
                              units_in   = 6'd1;
                              step_in    = ST_W1;
                           end else if (lam_ff) begin
                              sda_out_in = 1'b1;
                              sda_oe_in  = 1'b0;
                              units_in   = 6'd1;
                              step_in    = ST_WA1;
                           end else begin
                              ack_in   = 1'b1;
                              units_in = 6'd2;
                              step_in  = ST_WEND;
                           end
                        end
                        ST_WA1: begin
                           scl_out_in = 1'b1; units_in = 6'd2; step_in = ST_WA2;
                        end
                        ST_WA2: begin
                           ack_in     = q_item.sda_sample;
                           scl_out_in = 1'b0;
                           sda_oe_in  = 1'b1;
                           sda_out_in = 1'b0;
                           units_in   = 6'd2;
                           step_in    = ST_WEND;
                        end
                        ST_R0: begin
                           shift_in   = shift_up;
                           scl_out_in = 1'b1;
                           units_in   = 6'd2;
                           step_in    = ST_R1;
                        end
                        ST_R1: begin
                           shift_in   = shift_ff | {7'd0, q_item.sda_sample};
                           scl_out_in = 1'b0;
                           units_in   = 6'd1;
                           step_in    = ST_R2;
                        end
                        ST_R2: begin
                           bit_in = bit_up;
                           if (bit_up < 4'd8) begin
                              shift_in   = shift_up;
                              scl_out_in = 1'b1;
                              units_in   = 6'd2;
                              step_in    = ST_R1;
                           end else begin
                              sda_oe_in  = 1'b1;
                              sda_out_in = !lam_ff;
                              units_in   = 6'd2;
                              step_in    = ST_RA1;
                           end
                        end
                        ST_RA1: begin
                           scl_out_in = 1'b1; units_in = 6'd1; step_in = ST_RA2;
                        end
                        ST_RA2: begin
                           scl_out_in = 1'b0; units_in = 6'd2; step_in = ST_REND;
                        end
                        ST_REND: begin
                           rx_in = shift_ff; step_in = ST_IDLE; done = 1'b1;
                        end
                        default: begin
                           // start tail, write tail: sequence complete
                           step_in = ST_IDLE; done = 1'b1;
                        end
                     endcase
                  end
               end else begin
                  pre_in = pre_sum[15:0];
               end
            end
         end
         i2cm_pkg::OP_START: begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               ack_in   = 1'b0;
               pre_in   = 16'd0;
               units_in = 6'd50;
               step_in  = ST_S1;
            end
         end
         i2cm_pkg::OP_STOP: begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               sda_out_in = 1'b0;
               scl_out_in = 1'b0;
               pre_in     = 16'd0;
               units_in   = 6'd2;
               step_in    = ST_P1;
            end
         end
         i2cm_pkg::OP_WRITE: begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               shift_in   = q_item.tx_byte;
               lam_in     = q_item.ack_mode;
               bit_in     = 4'd0;
               sda_out_in = q_item.tx_byte[7];
               pre_in     = 16'd0;
               units_in   = 6'd1;
               step_in    = ST_W1;
            end
         end
         i2cm_pkg::OP_READ: begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               lam_in    = q_item.ack_mode;
               sda_oe_in = 1'b0;
               shift_in  = 8'd0;
               bit_in    = 4'd0;
               pre_in    = 16'd0;
               units_in  = 6'd1;
               step_in   = ST_R0;
            end
         end
         default: begin
            // unknown code: no effect
         end
      endcase
   end

   // Hold sequencer state and the response stage
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         pre_ff       <= 16'd0;
         units_ff     <= 6'd0;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         lam_ff       <= 1'b0;
         ack_ff       <= 1'b0;
         scl_out_ff   <= 1'b1;
         sda_out_ff   <= 1'b1;
         sda_oe_ff    <= 1'b1;
         rx_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            step_ff      <= step_in;
            pre_ff       <= pre_in;
            units_ff     <= units_in;
            bit_ff       <= bit_in;
            shift_ff     <= shift_in;
            lam_ff       <= lam_in;
            ack_ff       <= ack_in;
            scl_out_ff   <= scl_out_in;
            sda_out_ff   <= sda_out_in;
            sda_oe_ff    <= sda_oe_in;
            rx_ff        <= rx_in;
            rsp_valid_ff <= 1'b1;
            rsp_scl_ff   <= scl_out_in;
            rsp_sda_ff   <= sda_out_in;
            rsp_oe_ff    <= sda_oe_in;
            rsp_busy_ff  <= (step_in != ST_IDLE);
            rsp_done_ff  <= done;
            rsp_rx_ff    <= rx_in;
            rsp_ack_ff   <= ack_in;
            rsp_rej_ff   <= rej;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = rsp_scl_ff;
   assign rsp_sda_level = rsp_sda_ff;
   assign rsp_sda_drive = rsp_oe_ff;
   assign rsp_busy_res  = rsp_busy_ff;
   assign rsp_done_res  = rsp_done_ff;
   assign rsp_rx_byte   = rsp_rx_ff;
   assign rsp_ack_level = rsp_ack_ff;
   assign rsp_rejected  = rsp_rej_ff;

endmodule

>>> rtl/i2c_master_byte_engine.sv
// I2C master byte engine, top level.
// Request channel (req_*): one word per command or per tick. cmd 0 is a tick
// carrying the sampled SDA level in req_sda_in; 1 start, 2 stop, 3 write
// req_tx_byte, 4 read. All bus timing advances only on tick words.
// Response channel (rsp_*): exactly one word per request word, in order,
// giving the pin levels, busy/done, received byte, acknowledge flag and the
// rejected flag for a command that arrived while a sequence was running.
// Register port (csr_*): ticks_per_unit, always ready; write it while idle.
// An accepted request word is registered in the queue, then popped through
// the sequencer into the response register, from which rsp_valid offers it.
// Throughput: one word per cycle while rsp_ready holds; the sequencer updates
// all its state once per word, and the response register frees the front.
// When the receiver stalls, the response register holds its word and the
// queue (QUEUE_DEPTH words) keeps taking requests until full, then drops
// req_ready. Reset (synchronous) empties the queue, puts the sequencer idle
// with SCL and SDA driven high, and sets ticks_per_unit to 100.
`timescale 1ns / 1ps

module i2c_master_byte_engine #(
   parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_ack_mode,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_sda_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_level,
   output logic        rsp_rejected,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_ticks_per_unit
);

   logic [15:0]        tpu_ff;
   logic               q_valid;
   logic               q_pop;
   i2cm_pkg::item_type q_item;

   // Timing register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff <= i2cm_pkg::TICKS_PER_UNIT_RESET;
      end else if (csr_valid) begin
         tpu_ff <= csr_ticks_per_unit;
      end
   end

   i2cm_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_tx_byte  (req_tx_byte),
      .req_ack_mode (req_ack_mode),
      .req_sda_in   (req_sda_in),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop)
   );

   i2cm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .ticks_per_unit (tpu_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_ack_level  (rsp_ack_level),
      .rsp_rejected   (rsp_rejected)
   );

`ifndef NO_ASSERTIONS
   // A finishing sequence leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // A rejected command never disturbs a running sequence
   a_rej_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> (rsp_busy_res && !rsp_done_res))
      else $error("rejected command without a running sequence");

   // SDA is released only inside a sequence
   a_idle_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_busy_res) |-> rsp_sda_drive)
      else $error("SDA released while idle");

   // Reset empties the response stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");
`endif

endmodule

>>> tb/tb_i2c_master_byte_engine.sv
// Self-checking testbench for the I2C master byte engine (i2c_master_byte_engine).
// Depends on i2cm_pkg for the command codes and the reset value of ticks_per_unit.
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;

   // Command codes the block must ignore
   localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
   localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
   localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

   // Busy or command words wanted from the random phase
   localparam int RANDOM_WORDS = 500;

   // Steps of a command sequence
   typedef enum logic [4:0] {
      SQ_IDLE, SQ_S1, SQ_S2, SQ_S3, SQ_S4, SQ_S5, SQ_P1, SQ_P2,
      SQ_W1, SQ_W2, SQ_W3, SQ_WA1, SQ_WA2, SQ_WEND,
      SQ_R0, SQ_R1, SQ_R2, SQ_RA1, SQ_RA2, SQ_REND
   } seq_step_type;

   // One response word, fields in port order
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       drive;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic       ack;
      logic       rej;
   } bus_status_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      logic [2:0]     cmd;
      logic [7:0]     tx;
      logic           am;
      logic           sda;
      int             reps;
      logic [15:0]    tpu;
      bit             typed;
      bus_status_type want;
   } plan_row_type;

   // Responses that can be read straight off the spec
   localparam bus_status_type IDLE_AFTER_RESET   = {5'b11100, 8'h00, 2'b00};
   localparam bus_status_type STOP_ACCEPTED      = {5'b00110, 8'h00, 2'b00};
   localparam bus_status_type STOP_REFUSED_START = {5'b00110, 8'h00, 2'b01};
   localparam bus_status_type STOP_FINISHED      = {5'b11101, 8'h00, 2'b00};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_cmd;
   logic [7:0]  req_tx_byte;
   logic        req_ack_mode;
   logic        req_sda_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_sda_drive;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_ack_level;
   logic        rsp_rejected;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_ticks_per_unit;

   bus_status_type pending_status [$];
   plan_row_type   plan_q [$];
   int             fault_count = 0;
   int             live_words = 0;
   int             stall_left = 0;
   bit             steady = 1'b0;

   // Shadow copy of the engine state
   logic [15:0]  m_tpu;
   seq_step_type m_step;
   logic [16:0]  m_prescale;
   logic [5:0]   m_units;
   logic [3:0]   m_bit;
   logic [7:0]   m_shift;
   logic         m_lat_am;
   logic         m_ack;
   logic         m_scl;
   logic         m_sda;
   logic         m_sda_en;
   logic [7:0]   m_rx;

   i2c_master_byte_engine dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_tx_byte        (req_tx_byte),
      .req_ack_mode       (req_ack_mode),
      .req_sda_in         (req_sda_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_scl_level      (rsp_scl_level),
      .rsp_sda_level      (rsp_sda_level),
      .rsp_sda_drive      (rsp_sda_drive),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_rx_byte        (rsp_rx_byte),
      .rsp_ack_level      (rsp_ack_level),
      .rsp_rejected       (rsp_rejected),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_ticks_per_unit (csr_ticks_per_unit)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Load the state the block holds after reset
   function automatic void engine_reset();
      m_tpu      = i2cm_pkg::TICKS_PER_UNIT_RESET;
      m_step     = SQ_IDLE;
      m_prescale = '0;
      m_units    = '0;
      m_bit      = '0;
      m_shift    = '0;
      m_lat_am   = 1'b0;
      m_ack      = 1'b0;
      m_scl      = 1'b1;
      m_sda      = 1'b1;
      m_sda_en   = 1'b1;
      m_rx       = '0;
   endfunction

   function automatic void arm_wait(input logic [5:0] units, input seq_step_type nxt);
      m_units    = units;
      m_prescale = '0;
      m_step     = nxt;
   endfunction

   function automatic void begin_read_bit();
      m_shift = {m_shift[6:0], 1'b0};
      m_scl   = 1'b1;
      arm_wait(6'd2, SQ_R1);
   endfunction

   // Pin actions at the end of a wait; returns 1 when the sequence is over
   function automatic logic wait_expired(input logic sda_in);
      logic fin;
      fin = 1'b0;
      case (m_step)
         SQ_S1: begin m_sda = 1'b1; arm_wait(6'd1, SQ_S2); end
         SQ_S2: begin m_scl = 1'b1; arm_wait(6'd10, SQ_S3); end
         SQ_S3: begin m_sda = 1'b0; arm_wait(6'd1, SQ_S4); end
         SQ_S4: begin m_scl = 1'b0; arm_wait(6'd2, SQ_S5); end
         SQ_P1: begin m_scl = 1'b1; arm_wait(6'd2, SQ_P2); end
         SQ_P2: begin m_sda = 1'b1; fin = 1'b1; end
         SQ_W1: begin m_scl = 1'b1; arm_wait(6'd2, SQ_W2); end
         SQ_W2: begin m_scl = 1'b0; arm_wait(6'd1, SQ_W3); end
         SQ_W3: begin
            m_shift = {m_shift[6:0], 1'b0};
            m_bit   = m_bit + 4'd1;
            if (m_bit < 4'd8) begin
               m_sda = m_shift[7];
               arm_wait(6'd1, SQ_W1);
            end else if (m_lat_am) begin
               m_sda    = 1'b1;
               m_sda_en = 1'b0;
               arm_wait(6'd1, SQ_WA1);
            end else begin
               m_ack = 1'b1;
               arm_wait(6'd2, SQ_WEND);
            end
         end
         SQ_WA1: begin m_scl = 1'b1; arm_wait(6'd2, SQ_WA2); end
         SQ_WA2: begin
            m_ack    = sda_in;
            m_scl    = 1'b0;
            m_sda_en = 1'b1;
            m_sda    = 1'b0;
            arm_wait(6'd2, SQ_WEND);
         end
         SQ_R0: begin_read_bit();
         SQ_R1: begin
            m_shift = m_shift | {7'd0, sda_in};
            m_scl   = 1'b0;
            arm_wait(6'd1, SQ_R2);
         end
         SQ_R2: begin
            m_bit = m_bit + 4'd1;
            if (m_bit < 4'd8) begin
               begin_read_bit();
            end else begin
               m_sda_en = 1'b1;
               m_sda    = ~m_lat_am;
               arm_wait(6'd2, SQ_RA1);
            end
         end
         SQ_RA1: begin m_scl = 1'b1; arm_wait(6'd1, SQ_RA2); end
         SQ_RA2: begin m_scl = 1'b0; arm_wait(6'd2, SQ_REND); end
         SQ_REND: begin m_rx = m_shift; fin = 1'b1; end
         default: fin = 1'b1;
      endcase
      if (fin) begin
         m_step     = SQ_IDLE;
         m_units    = '0;
         m_prescale = '0;
      end
      return fin;
   endfunction

   // Advance the shadow engine by one request word and return its response
   function automatic bus_status_type engine_next_status(input logic [2:0] cmd,
                                                         input logic [7:0] tx,
                                                         input logic am,
                                                         input logic sda_in);
      bus_status_type st;
      logic           busy;
      logic           done;
      logic           rej;
      logic [16:0]    unit_len;
      busy = (m_step != SQ_IDLE);
      done = 1'b0;
      rej  = 1'b0;
      if (cmd == i2cm_pkg::CMD_TICK) begin
         if (busy) begin
            unit_len   = (m_tpu == 16'd0) ? 17'd1 : {1'b0, m_tpu};
            m_prescale = m_prescale + 17'd1;
            if (m_prescale >= unit_len) begin
               m_prescale = '0;
               if (m_units != 6'd0) m_units = m_units - 6'd1;
               if (m_units == 6'd0) done = wait_expired(sda_in);
            end
         end
      end else if (cmd <= i2cm_pkg::CMD_READ) begin
         if (busy) begin
            rej = 1'b1;
         end else if (cmd == i2cm_pkg::CMD_START) begin
            m_ack = 1'b0;
            arm_wait(6'd50, SQ_S1);
         end else if (cmd == i2cm_pkg::CMD_STOP) begin
            m_sda = 1'b0;
            m_scl = 1'b0;
            arm_wait(6'd2, SQ_P1);
         end else if (cmd == i2cm_pkg::CMD_WRITE) begin
            m_shift  = tx;
            m_lat_am = am;
            m_bit    = '0;
            m_sda    = tx[7];
            arm_wait(6'd1, SQ_W1);
         end else begin
            m_lat_am = am;
            m_sda_en = 1'b0;
            m_shift  = '0;
            m_bit    = '0;
            arm_wait(6'd1, SQ_R0);
         end
      end
      st = {m_scl, m_sda, m_sda_en, (m_step != SQ_IDLE), done, m_rx, m_ack, rej};
      return st;
   endfunction

   // Gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_row(input logic [2:0] cmd, input logic [7:0] tx,
                                   input logic am, input logic sda, input int reps,
                                   input bit typed = 1'b0,
                                   input bus_status_type want = '0);
      plan_row_type row;
      row.kind  = ROW_WORD;
      row.cmd   = cmd;
      row.tx    = tx;
      row.am    = am;
      row.sda   = sda;
      row.reps  = reps;
      row.tpu   = '0;
      row.typed = typed;
      row.want  = want;
      plan_q.push_back(row);
   endfunction

   function automatic void add_csr(input logic [15:0] value);
      plan_row_type row;
      row.kind  = ROW_CSR;
      row.cmd   = i2cm_pkg::CMD_TICK;
      row.tx    = '0;
      row.am    = 1'b0;
      row.sda   = 1'b0;
      row.reps  = 0;
      row.tpu   = value;
      row.typed = 1'b0;
      row.want  = '0;
      plan_q.push_back(row);
   endfunction

   // Offer one request word, hold it until taken, then log what must come back
   task automatic send_word(input logic [2:0] cmd, input logic [7:0] tx, input logic am,
                            input logic sda, input bit typed = 1'b0,
                            input bus_status_type want = '0);
      int             gap;
      logic           was_busy;
      bus_status_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_tx_byte  <= tx;
      req_ack_mode <= am;
      req_sda_in   <= sda;
      do @(posedge clock); while (!req_ready);
      was_busy  = (m_step != SQ_IDLE);
      predicted = engine_next_status(cmd, tx, am, sda);
      pending_status.push_back(typed ? want : predicted);
      if (was_busy || (cmd >= i2cm_pkg::CMD_START && cmd <= i2cm_pkg::CMD_READ))
         live_words++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every response is back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_tpu(input logic [15:0] value);
      csr_valid          <= 1'b1;
      csr_ticks_per_unit <= value;
      do @(posedge clock); while (!csr_ready);
      m_tpu = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random tick word with random SDA
   task automatic send_tick();
      send_word(i2cm_pkg::CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
   endtask

   // Issue a command, then tick with random SDA until the engine is idle again,
   // scattering stray commands that must be refused or ignored
   task automatic issue(input logic [2:0] cmd, input logic [7:0] tx, input logic am);
      send_word(cmd, tx, am, 1'($urandom_range(0, 1)));
      while (m_step != SQ_IDLE) begin
         if ($urandom_range(0, 99) < 4)
            send_word(3'($urandom_range(i2cm_pkg::CMD_START, CMD_UNUSED_HI)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         else
            send_tick();
      end
      repeat ($urandom_range(0, 2))
         send_tick();
   endtask

   task automatic check_field(input string label, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s expected %0h got %0h", $time, label, want_v, got_v);
         fault_count++;
      end
   endtask

   // Receiver side: stall at random
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // Compare each response word with the oldest expectation
   always @(posedge clock) begin : watch_rsp
      bus_status_type got;
      bus_status_type want;
      got = {rsp_scl_level, rsp_sda_level, rsp_sda_drive, rsp_busy_res, rsp_done_res,
             rsp_rx_byte, rsp_ack_level, rsp_rejected};
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            $display("%0t: response expected none got %h", $time, got);
            fault_count++;
         end else begin
            want = pending_status.pop_front();
            check_field("scl_level", 8'(want.scl), 8'(got.scl));
            check_field("sda_level", 8'(want.sda), 8'(got.sda));
            check_field("sda_drive", 8'(want.drive), 8'(got.drive));
            check_field("busy_res", 8'(want.busy), 8'(got.busy));
            check_field("done_res", 8'(want.done), 8'(got.done));
            check_field("rx_byte", want.rx, got.rx);
            check_field("ack_level", 8'(want.ack), 8'(got.ack));
            check_field("rejected", 8'(want.rej), 8'(got.rej));
         end
      end
   end

   initial begin : stimulus
      int           pick;
      plan_row_type row;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_cmd            = i2cm_pkg::CMD_TICK;
      req_tx_byte        = 8'h00;
      req_ack_mode       = 1'b0;
      req_sda_in         = 1'b0;
      rsp_ready          = 1'b0;
      csr_valid          = 1'b0;
      csr_ticks_per_unit = i2cm_pkg::TICKS_PER_UNIT_RESET;
      engine_reset();

      // Directed plan, first at the reset unit length
      add_row(i2cm_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1, 1'b1, IDLE_AFTER_RESET);
      add_row(i2cm_pkg::CMD_TICK, 8'hFF, 1'b1, 1'b1, 1, 1'b1, IDLE_AFTER_RESET);
      add_row(CMD_UNUSED_LO, 8'hFF, 1'b1, 1'b1, 1, 1'b1, IDLE_AFTER_RESET);
      add_row(CMD_UNUSED_HI, 8'h00, 1'b0, 1'b0, 1, 1'b1, IDLE_AFTER_RESET);
      add_row(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 1, 1'b1, STOP_ACCEPTED);
      add_row(i2cm_pkg::CMD_START, 8'hFF, 1'b1, 1'b1, 1, 1'b1, STOP_REFUSED_START);
      add_row(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b1, 1);
      add_row(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 1'b0, 1);
      add_row(CMD_UNUSED_MID, 8'h5A, 1'b0, 1'b1, 1);
      add_row(i2cm_pkg::CMD_TICK, 8'h00, 1'b0, 1'b1, 399);
      add_row(i2cm_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1, 1'b1, STOP_FINISHED);
      // One tick per unit: full frame with both acknowledge levels and a read
      add_csr(16'd1);
      add_row(i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 1);
      add_row(i2cm_pkg::CMD_TICK, 8'h00, 1'b0, 1'b1, 70);
      add_row(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b0, 1);
      add_row(i2cm_pkg::CMD_TICK, 8'h00, 1'b0, 1'b1, 40);
      add_row(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b1, 1);
      add_row(i2cm_pkg::CMD_TICK, 8'hFF, 1'b1, 1'b0, 40);
      add_row(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0, 1);
      add_row(i2cm_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 40);
      add_row(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 1'b0, 1);
      add_row(i2cm_pkg::CMD_TICK, 8'h00, 1'b0, 1'b1, 34);
      add_row(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 1);
      add_row(i2cm_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 6);
      // Zero unit length behaves as one tick
      add_csr(16'd0);
      add_row(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 1);
      add_row(i2cm_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 6);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed plan
      foreach (plan_q[i]) begin
         row = plan_q[i];
         if (row.kind == ROW_CSR) begin
            settle();
            program_tpu(row.tpu);
         end else begin
            for (int n = 0; n < row.reps; n++)
               send_word(row.cmd, row.tx, row.am, row.sda,
                         row.typed && (n == row.reps - 1), row.want);
         end
      end

      // Random phases: mostly well-formed frames, some stray commands
      live_words = 0;
      while (live_words < RANDOM_WORDS) begin
         settle();
         pick = $urandom_range(0, 9);
         program_tpu(pick < 6 ? 16'd1 : (pick == 6 ? 16'd0 : 16'(pick - 5)));
         steady = ($urandom_range(0, 4) == 0);
         repeat (2) begin
            if ($urandom_range(0, 9) < 8) begin
               issue(i2cm_pkg::CMD_START, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
               repeat ($urandom_range(1, 3)) begin
                  if ($urandom_range(0, 1))
                     issue(i2cm_pkg::CMD_WRITE, 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
                  else
                     issue(i2cm_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
               end
               issue(i2cm_pkg::CMD_STOP, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
            end else begin
               issue(3'($urandom_range(i2cm_pkg::CMD_START, CMD_UNUSED_HI)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
         end
      end

      // Longest unit: start a stop and count ticks into its first wait
      settle();
      program_tpu(16'hFFFF);
      steady = 1'b1;
      send_word(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);
      repeat (40) send_tick();

      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fault_count == 0)
         $display("tb_i2c_master_byte_engine: clean");
      else
         $display("tb_i2c_master_byte_engine: errors");
      $finish;
   end

   // Hard stop if the run hangs
   initial begin : watchdog
      #30_000_000;
      $display("tb_i2c_master_byte_engine: errors");
      $finish;
   end

endmodule
